### rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  // Field widths of the channel words
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Character code that moves the cursor to the next line
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // Configuration register indexes and reset values
  localparam logic [1:0] REG_TEXT_COLOR   = 2'd0;
  localparam logic [1:0] REG_CURSOR_COLOR = 2'd1;
  localparam logic [1:0] REG_CURSOR_GLYPH = 2'd2;

  localparam logic [7:0] TEXT_COLOR_RST   = 8'd7;
  localparam logic [7:0] CURSOR_COLOR_RST = 8'd15;
  localparam logic [7:0] CURSOR_GLYPH_RST = 8'd95;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCROLL,
    S_CLEAR,
    S_GLYPH,
    S_DONE
  } state_t;

endpackage

### rtl/core/tcw_if.sv
// Valid/ready channel interfaces for the input and result words.
interface tcw_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::OP_W-1:0]    operation;
  logic [tcw_pkg::CHAR_W-1:0]  character;
  logic                        first_of_string;
  logic                        last_of_string;
  logic [tcw_pkg::RROW_W-1:0]  read_row;
  logic [tcw_pkg::RCOL_W-1:0]  read_col;

  modport source (output valid, operation, character, first_of_string, last_of_string,
                  read_row, read_col, input ready);
  modport sink (input valid, operation, character, first_of_string, last_of_string,
                read_row, read_col, output ready);
endinterface

interface tcw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::CHAR_W-1:0]  cell_character;
  logic [tcw_pkg::ATTR_W-1:0]  cell_color;
  logic [tcw_pkg::RCOL_W-1:0]  cursor_column;
  logic [tcw_pkg::RROW_W-1:0]  cursor_row;
  logic                        scrolled;

  modport source (output valid, cell_character, cell_color, cursor_column, cursor_row,
                  scrolled, input ready);
  modport sink (input valid, cell_character, cell_color, cursor_column, cursor_row,
                scrolled, output ready);
endinterface

### rtl/core/text_console_writer_top.sv
// Text console writer: cell memory, cursor and a small sequencer around one address adder.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+----------------------------------------------
//  in_ch    | in  | valid/ready        | operation, character, first/last, read row/col
//  out_ch   | out | valid/ready        | cell char/color, cursor column/row, scrolled
//  cfg_*    | in  | APB, pready high   | text_color, cursor_color, cursor_glyph
//
//  Put: accept, then one cell write; a further cell write when the cursor glyph is drawn.
//  Scroll: rows are copied up and the bottom row is zeroed, one cell copied or zeroed per cycle.
//  Clear: every cell is zeroed. Read: accept, then a memory read (memory read port is registered).
//  After reset a clearing pass over every cell runs before the first word is taken.
//  A finished result is held in the output register; a stalled sink holds the
//  sequencer in its finish state until the register frees up.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_ch,
  tcw_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW8   = tcw_pkg::RCOL_W + 1;
  localparam int RW7   = tcw_pkg::RROW_W + 2;
  localparam logic [AW-1:0] SCROLL_LAST = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] CELL_LAST   = AW'(CELLS - 1);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);

  // Configuration registers
  logic [7:0] text_color_r, cursor_color_r, cursor_glyph_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r   <= tcw_pkg::TEXT_COLOR_RST;
      cursor_color_r <= tcw_pkg::CURSOR_COLOR_RST;
      cursor_glyph_r <= tcw_pkg::CURSOR_GLYPH_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        tcw_pkg::REG_TEXT_COLOR:   text_color_r   <= cfg_pwdata[7:0];
        tcw_pkg::REG_CURSOR_COLOR: cursor_color_r <= cfg_pwdata[7:0];
        tcw_pkg::REG_CURSOR_GLYPH: cursor_glyph_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      tcw_pkg::REG_TEXT_COLOR:   cfg_prdata = {24'd0, text_color_r};
      tcw_pkg::REG_CURSOR_COLOR: cfg_prdata = {24'd0, cursor_color_r};
      tcw_pkg::REG_CURSOR_GLYPH: cfg_prdata = {24'd0, cursor_glyph_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // Sequencer and datapath registers
  tcw_pkg::state_t             state_r, state_nxt;
  logic                        init_r, init_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               col_r, col_nxt;
  logic [RW-1:0]               row_r, row_nxt;
  logic [tcw_pkg::OP_W-1:0]    op_r;
  logic [tcw_pkg::CHAR_W-1:0]  ch_r;
  logic                        first_r, last_r;
  logic [tcw_pkg::RROW_W-1:0]  rrow_r;
  logic [tcw_pkg::RCOL_W-1:0]  rcol_r;
  logic [tcw_pkg::CHAR_W-1:0]  res_ch_r, res_ch_nxt;
  logic [tcw_pkg::ATTR_W-1:0]  res_attr_r, res_attr_nxt;
  logic                        res_scr_r, res_scr_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CHAR_W-1:0]  out_ch_r;
  logic [tcw_pkg::ATTR_W-1:0]  out_attr_r;
  logic [tcw_pkg::RCOL_W-1:0]  out_col_r;
  logic [tcw_pkg::RROW_W-1:0]  out_row_r;
  logic                        out_scr_r;

  // Cell memory, one write and one registered read per cycle
  logic [tcw_pkg::CELL_W-1:0]  mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0]  rd_data_r;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]  mem_wdata;

  // Shared address adder: row*COLUMNS + column, or scroll source index
  logic [RW7-1:0]              rrow_w;
  logic [CW8-1:0]              rcol_w;
  logic                        rd_in_range;
  logic                        sel_rd;
  logic [RW-1:0]               mul_row;
  logic [CW-1:0]               mul_col;
  logic [AW-1:0]               add_a, add_b, addr_sum;

  assign rrow_w      = {2'b00, rrow_r};
  assign rcol_w      = {1'b0, rcol_r};
  assign rd_in_range = (rrow_w < RW7'(ROWS)) && (rcol_w < CW8'(COLUMNS));
  assign sel_rd      = (state_r == tcw_pkg::S_EXEC) && (op_r == tcw_pkg::OP_READ);
  assign mul_row     = sel_rd ? rrow_w[RW-1:0] : row_r;
  assign mul_col     = sel_rd ? rcol_w[CW-1:0] : col_r;
  assign add_a       = (state_r == tcw_pkg::S_SCROLL) ? idx_r
                                                      : AW'(mul_row) * AW'(COLUMNS);
  assign add_b       = (state_r == tcw_pkg::S_SCROLL) ? AW'(COLUMNS) : AW'(mul_col);
  assign addr_sum    = add_a + add_b;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[addr_sum];
    end
  end

  // Handshake
  logic out_free;
  logic fin;
  logic is_nl;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == tcw_pkg::S_IDLE);
  assign is_nl       = (ch_r == tcw_pkg::NEWLINE_CODE);

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    res_ch_nxt    = res_ch_r;
    res_attr_nxt  = res_attr_r;
    res_scr_nxt   = res_scr_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = addr_sum;
    mem_wdata     = '0;
    fin           = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      tcw_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = tcw_pkg::S_EXEC;
        end
      end

      tcw_pkg::S_EXEC: begin
        res_ch_nxt   = '0;
        res_attr_nxt = '0;
        res_scr_nxt  = 1'b0;
        case (tcw_pkg::op_t'(op_r))
          tcw_pkg::OP_PUT: begin
            // a printable byte overwrites the erase, so one write covers both
            mem_we    = first_r || !is_nl;
            mem_wdata = {text_color_r, is_nl ? tcw_pkg::CHAR_W'(0) : ch_r};
            if (is_nl || col_r == COL_LAST) begin
              col_nxt = '0;
              if (row_r == ROW_LAST) begin
                res_scr_nxt = 1'b1;
              end else begin
                row_nxt = row_r + RW'(1);
              end
            end else begin
              col_nxt = col_r + CW'(1);
            end
            if (res_scr_nxt) begin
              idx_nxt   = '0;
              state_nxt = tcw_pkg::S_SCROLL;
            end else if (last_r) begin
              state_nxt = tcw_pkg::S_GLYPH;
            end else begin
              fin = 1'b1;
            end
          end
          tcw_pkg::OP_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            idx_nxt   = '0;
            state_nxt = tcw_pkg::S_CLEAR;
          end
          tcw_pkg::OP_READ: begin
            if (rd_in_range) begin
              mem_re    = 1'b1;
              state_nxt = tcw_pkg::S_RDWAIT;
            end else begin
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
      end

      tcw_pkg::S_RDWAIT: begin
        res_ch_nxt   = rd_data_r[tcw_pkg::CHAR_W-1:0];
        res_attr_nxt = rd_data_r[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        fin          = 1'b1;
      end

      // copy cell idx+COLUMNS down to idx; the write follows its read in the next cycle
      tcw_pkg::S_SCROLL: begin
        mem_re    = (idx_r != SCROLL_LAST);
        mem_we    = (idx_r != '0);
        mem_waddr = idx_r - AW'(1);
        mem_wdata = rd_data_r;
        if (idx_r == SCROLL_LAST) begin
          state_nxt = tcw_pkg::S_CLEAR;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      // zero cells from idx to the last cell: reset pass, clear item, bottom row
      tcw_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = '0;
        if (idx_r == CELL_LAST) begin
          idx_nxt = '0;
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = tcw_pkg::S_IDLE;
          end else if (op_r == tcw_pkg::OP_PUT && last_r) begin
            state_nxt = tcw_pkg::S_GLYPH;
          end else begin
            fin = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      tcw_pkg::S_GLYPH: begin
        mem_we    = 1'b1;
        mem_wdata = {cursor_color_r, cursor_glyph_r};
        fin       = 1'b1;
      end

      tcw_pkg::S_DONE: fin = 1'b1;

      default: state_nxt = tcw_pkg::S_IDLE;
    endcase

    // finish: load the result word once the output register is free
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        state_nxt     = tcw_pkg::S_IDLE;
      end else begin
        state_nxt = tcw_pkg::S_DONE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::S_CLEAR;
      init_r      <= 1'b1;
      idx_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_ch_r   <= res_ch_nxt;
    res_attr_r <= res_attr_nxt;
    res_scr_r  <= res_scr_nxt;
    if (in_ch.valid && in_ch.ready) begin
      op_r    <= in_ch.operation;
      ch_r    <= in_ch.character;
      first_r <= in_ch.first_of_string;
      last_r  <= in_ch.last_of_string;
      rrow_r  <= in_ch.read_row;
      rcol_r  <= in_ch.read_col;
    end
    if (fin && out_free) begin
      out_ch_r   <= res_ch_nxt;
      out_attr_r <= res_attr_nxt;
      out_col_r  <= tcw_pkg::RCOL_W'(col_nxt);
      out_row_r  <= tcw_pkg::RROW_W'(row_nxt);
      out_scr_r  <= res_scr_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cell_character = out_ch_r;
  assign out_ch.cell_color     = out_attr_r;
  assign out_ch.cursor_column  = out_col_r;
  assign out_ch.cursor_row     = out_row_r;
  assign out_ch.scrolled       = out_scr_r;

`ifndef SYNTH
  // cursor always stays on the grid
  a_cursor_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= COL_LAST) && (row_r <= ROW_LAST))
    else $error("cursor left the grid");

  // no word is taken during the power-up clearing pass
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !in_ch.ready)
    else $error("input taken during clearing pass");

  // a scroll only runs with the cursor parked on the bottom row, column zero
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::S_SCROLL) |-> (row_r == ROW_LAST && col_r == '0))
    else $error("scroll with cursor off the bottom row");

  // the scroll copy never reads and writes the same cell in one cycle
  a_scroll_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::S_SCROLL && mem_we && mem_re) |-> (mem_waddr != addr_sum))
    else $error("scroll read and write collide");
`endif

endmodule
